>>> sv/shg_pkg.sv
// ----------------------------------------------------------------------------
// shg_pkg
// Shared types, constants and helpers for the spatial hash grid search.
// ----------------------------------------------------------------------------
package shg_pkg;

    localparam int MAX_POINTS      = 1024;
    localparam int POINT_W         = 10;
    localparam int COUNT_W         = 11;
    localparam int MAX_BUCKETS     = 4096;
    localparam int BUCKET_W        = 12;
    localparam int COORD_W         = 32;
    localparam int SPACING_W       = 31;
    localparam int RES_W           = 5;
    localparam int WRAP_W          = 4;
    localparam int MATCH_W         = 6;
    localparam int MAX_MATCHES_DEF = 63;
    localparam int NEAR_CELLS      = 8;
    localparam int CELL_W          = 3;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 31'd65536;
    localparam logic [RES_W-1:0]     RES_MAX       = 5'd16;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_ALL   = 2'd2,
        CMD_ANY   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_MATCH  = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_SPACING = 2'd0,
        REG_RES_X   = 2'd1,
        REG_RES_Y   = 2'd2,
        REG_RES_Z   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic                 done;
        logic [COORD_W-1:0]   quo;
        logic [SPACING_W-1:0] rem;
    } div_res_t;

    typedef struct packed {
        logic done;
        logic hit;
    } dist_res_t;

    typedef struct packed {
        kind_t              kind;
        logic [POINT_W-1:0] idx;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               found;
        logic               trunc;
        logic               status;
        logic               last;
    } out_t;

    function automatic logic [RES_W-1:0] res_eff(input logic [RES_W-1:0] r);
        logic [RES_W-1:0] v;
        v = r;
        if (r == '0)
            v = 5'd1;
        else if (r > RES_MAX)
            v = RES_MAX;
        return v;
    endfunction

    // wrapped cell index along an axis: the cell itself, or a neighbor one step off when step is set
    function automatic logic [WRAP_W-1:0] nb_wrap(input logic [WRAP_W-1:0] w,
                                                  input logic [RES_W-1:0] r,
                                                  input logic step,
                                                  input logic pos);
        logic [RES_W-1:0] up;
        logic [WRAP_W-1:0] v;
        up = {1'b0, w} + 5'd1;
        v = w;
        if (step)
        begin
            if (pos)
                v = (up == r) ? '0 : up[WRAP_W-1:0];
            else
                v = (w == '0) ? WRAP_W'(r - 5'd1) : w - 4'd1;
        end
        return v;
    endfunction

    function automatic out_t mk_out(input kind_t k, input logic [POINT_W-1:0] i,
                                    input logic [3*COORD_W-1:0] p, input logic f,
                                    input logic t, input logic s, input logic l);
        out_t o;
        o.kind   = k;
        o.idx    = i;
        o.x      = p[COORD_W-1:0];
        o.y      = p[2*COORD_W-1:COORD_W];
        o.z      = p[3*COORD_W-1:2*COORD_W];
        o.found  = f;
        o.trunc  = t;
        o.status = s;
        o.last   = l;
        return o;
    endfunction

endpackage

>>> sv/shg_div.sv
// ----------------------------------------------------------------------------
// shg_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module shg_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [shg_pkg::COORD_W-1:0]      dividend,
    input  logic [shg_pkg::SPACING_W-1:0]    divisor,
    output shg_pkg::div_res_t                res
);

    logic                             busy_reg;
    logic [4:0]                       cnt_reg;
    logic                             done_reg;
    logic [shg_pkg::COORD_W-1:0]      dvd_reg;
    logic [shg_pkg::SPACING_W-1:0]    dvs_reg;
    logic [shg_pkg::SPACING_W-1:0]    rem_reg;
    logic [shg_pkg::COORD_W-1:0]      trial;
    logic                             fits;

    assign trial = {rem_reg, dvd_reg[shg_pkg::COORD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            dvd_reg  <= '0;
            dvs_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (fits)
                    rem_reg <= shg_pkg::SPACING_W'(trial - {1'b0, dvs_reg});
                else
                    rem_reg <= trial[shg_pkg::SPACING_W-1:0];
                dvd_reg <= {dvd_reg[shg_pkg::COORD_W-2:0], fits};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.quo  = dvd_reg;
    assign res.rem  = rem_reg;

endmodule

>>> sv/shg_dist.sv
// ----------------------------------------------------------------------------
// shg_dist
// Squared distance check with one shared 31x31 multiplier.
// ----------------------------------------------------------------------------
module shg_dist (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [3*shg_pkg::COORD_W-1:0]  pt,
    input  logic [shg_pkg::COORD_W-1:0]    o_x,
    input  logic [shg_pkg::COORD_W-1:0]    o_y,
    input  logic [shg_pkg::COORD_W-1:0]    o_z,
    input  logic [shg_pkg::SPACING_W-1:0]  rad,
    output shg_pkg::dist_res_t             res
);

    logic [2:0]  step_reg;
    logic [32:0] dx_reg, dy_reg, dz_reg;
    logic [32:0] dx, dy, dz;
    logic        far_reg;
    logic [61:0] prod_reg;
    logic [63:0] acc_reg;
    logic        done_reg;
    logic        hit_reg;
    logic [30:0] op;
    logic signed [32:0] sx, sy, sz;

    assign sx = $signed({pt[31], pt[31:0]}) - $signed({o_x[31], o_x});
    assign sy = $signed({pt[63], pt[63:32]}) - $signed({o_y[31], o_y});
    assign sz = $signed({pt[95], pt[95:64]}) - $signed({o_z[31], o_z});
    assign dx = sx[32] ? 33'(-sx) : 33'(sx);
    assign dy = sy[32] ? 33'(-sy) : 33'(sy);
    assign dz = sz[32] ? 33'(-sz) : 33'(sz);

    always_comb
    begin
        case (step_reg)
            3'd1:    op = dx_reg[30:0];
            3'd2:    op = dy_reg[30:0];
            3'd3:    op = dz_reg[30:0];
            default: op = rad;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
            hit_reg  <= 1'b0;
            far_reg  <= 1'b0;
            dx_reg   <= '0;
            dy_reg   <= '0;
            dz_reg   <= '0;
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                dx_reg   <= dx;
                dy_reg   <= dy;
                dz_reg   <= dz;
                far_reg  <= (dx > {2'b0, rad}) || (dy > {2'b0, rad}) || (dz > {2'b0, rad});
                acc_reg  <= '0;
                step_reg <= 3'd1;
            end
            else if (step_reg != '0)
            begin
                if (step_reg <= 3'd4)
                    prod_reg <= op * op;
                if (step_reg >= 3'd2 && step_reg <= 3'd4)
                    acc_reg <= acc_reg + {2'b0, prod_reg};
                if (step_reg == 3'd5)
                begin
                    hit_reg  <= !far_reg && (acc_reg <= {2'b0, prod_reg});
                    done_reg <= 1'b1;
                    step_reg <= '0;
                end
                else
                    step_reg <= step_reg + 3'd1;
            end
        end
    end

    assign res.done = done_reg;
    assign res.hit  = hit_reg;

endmodule

>>> sv/spatial_hash_grid_neighbor_search.sv
// Request taken to result: clear and full-store add are answered directly from idle; an add
//   runs three axes of two divides each (spacing, then cells per axis), then bucket lookup
//   and linking. Query: cell keying by the same divides, then for each of the eight near
//   cells a bucket lookup and a distance check per bucket entry scanned; a stalled result
//   holds the scan. One request at a time; the input stalls until the last result is taken.
// Reset: 1.0 spacing, 16 cells per axis, store empty; bucket heads cleared first.
// ----------------------------------------------------------------------------
// spatial_hash_grid_neighbor_search
// Hashed 3D grid point store with radius search under a small sequencer.
// ----------------------------------------------------------------------------
module spatial_hash_grid_neighbor_search #(
    parameter int MAX_MATCHES = shg_pkg::MAX_MATCHES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [31:0] coord_x,
    input  logic [31:0] coord_y,
    input  logic [31:0] coord_z,
    input  logic [30:0] radius,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [9:0]  point_index,
    output logic [31:0] match_x,
    output logic [31:0] match_y,
    output logic [31:0] match_z,
    output logic        found,
    output logic        truncated,
    output logic        status,
    output logic        last
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_SGO      = 16'h0002,
        S_DIV_S    = 16'h0004,
        S_DIV_R    = 16'h0008,
        S_KEY      = 16'h0010,
        S_HRD      = 16'h0020,
        S_KRD      = 16'h0040,
        S_CHK      = 16'h0080,
        S_ADD_WR   = 16'h0100,
        S_ADD_LINK = 16'h0200,
        S_SCAN     = 16'h0400,
        S_DGO      = 16'h0800,
        S_DWAIT    = 16'h1000,
        S_NEXT     = 16'h2000,
        S_OUT      = 16'h4000,
        S_INIT     = 16'h8000
    } state_t;

    localparam int PW = shg_pkg::POINT_W;
    localparam int KW = shg_pkg::BUCKET_W;
    localparam int WW = shg_pkg::WRAP_W;

    state_t state_reg, ret_reg;
    logic [shg_pkg::SPACING_W-1:0] spacing_reg;
    logic [shg_pkg::RES_W-1:0]     rx_reg, ry_reg, rz_reg;
    shg_pkg::cmd_t                 cmd_reg;
    logic [31:0]                   ox_reg, oy_reg, oz_reg;
    logic [30:0]                   rad_reg;
    logic [shg_pkg::COUNT_W-1:0]   count_reg;
    logic [1:0]                    axis_reg;
    logic                          cneg_reg;
    logic [WW-1:0]                 wx_reg, wy_reg, wz_reg;
    logic [2:0]                    dpos_reg;
    logic [shg_pkg::CELL_W-1:0]    cidx_reg;
    logic [KW-1:0]                 key_reg;
    logic [KW-1:0]                 clr_reg;
    logic [PW-1:0]                 head_q, tail_q, cur_reg;
    logic [KW-1:0]                 kq;
    logic [95:0]                   pt_q;
    logic [PW:0]                   nx_q;
    logic [shg_pkg::MATCH_W-1:0]   n_reg;
    logic                          any_reg, trunc_reg, hvalid_reg;
    shg_pkg::out_t                 out_reg;
    logic                          out_valid_reg;

    logic [95:0] pt_mem [shg_pkg::MAX_POINTS];
    logic [PW:0] nx_mem [shg_pkg::MAX_POINTS];
    logic [KW-1:0] key_mem [shg_pkg::MAX_POINTS];
    logic [PW-1:0] head_mem [shg_pkg::MAX_BUCKETS];
    logic [PW-1:0] tail_mem [shg_pkg::MAX_BUCKETS];

    logic [shg_pkg::SPACING_W-1:0] s_eff;
    logic [shg_pkg::RES_W-1:0]     ex, ey, ez, r_axis;
    logic [31:0]                   o_axis, o_abs;
    logic                          div_start;
    logic [31:0]                   div_dvd;
    logic [shg_pkg::SPACING_W-1:0] div_dvs;
    shg_pkg::div_res_t             div_res;
    shg_pkg::dist_res_t            dist_res;
    logic                          neg_o, rem_nz, cneg, dpos;
    logic [31:0]                   mag;
    logic [WW-1:0]                 wrem, wnew;
    logic [WW-1:0]                 kx, ky, kz;
    logic [7:0]                    kzy;
    logic [KW-1:0]                 key_c;
    logic                          hv;
    logic                          in_acc, out_acc;
    logic [PW-1:0]                 cnt_idx;

    assign s_eff = (spacing_reg == '0) ? 31'd1 : spacing_reg;
    assign ex = shg_pkg::res_eff(rx_reg);
    assign ey = shg_pkg::res_eff(ry_reg);
    assign ez = shg_pkg::res_eff(rz_reg);
    assign cnt_idx = count_reg[PW-1:0];

    always_comb
    begin
        case (axis_reg)
            2'd0:    begin o_axis = ox_reg; r_axis = ex; end
            2'd1:    begin o_axis = oy_reg; r_axis = ey; end
            default: begin o_axis = oz_reg; r_axis = ez; end
        endcase
    end

    assign neg_o  = o_axis[31];
    assign o_abs  = neg_o ? 32'(-o_axis) : o_axis;
    assign rem_nz = div_res.rem != '0;
    // floor division: a negative input rounds its quotient away from zero
    assign mag    = div_res.quo + {31'b0, neg_o && rem_nz};
    assign cneg   = neg_o && (mag != '0);
    assign dpos   = neg_o ? (rem_nz && ({1'b0, s_eff} >= {div_res.rem, 1'b0}))
                          : ({div_res.rem, 1'b0} >= {1'b0, s_eff});
    assign wrem   = div_res.rem[WW-1:0];
    assign wnew   = (cneg_reg && wrem != '0) ? WW'(r_axis - {1'b0, wrem}) : wrem;

    assign div_start = (state_reg == S_SGO) || (state_reg == S_DIV_S && div_res.done);
    assign div_dvd   = (state_reg == S_SGO) ? o_abs : mag;
    assign div_dvs   = (state_reg == S_SGO) ? s_eff : {26'b0, r_axis};

    assign kx = shg_pkg::nb_wrap(wx_reg, ex, cidx_reg[2], dpos_reg[0]);
    assign ky = shg_pkg::nb_wrap(wy_reg, ey, cidx_reg[1], dpos_reg[1]);
    assign kz = shg_pkg::nb_wrap(wz_reg, ez, cidx_reg[0], dpos_reg[2]);
    assign kzy   = 8'({4'b0, kz} * {3'b0, ez}) + {4'b0, ky};
    assign key_c = KW'({4'b0, kzy} * {7'b0, ex}) + {8'b0, kx};

    assign hv = ({1'b0, head_q} < count_reg) && (kq == key_reg);

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;

    shg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .res      (div_res)
    );

    shg_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DGO),
        .pt    (pt_q),
        .o_x   (ox_reg),
        .o_y   (oy_reg),
        .o_z   (oz_reg),
        .rad   (rad_reg),
        .res   (dist_res)
    );

    // storage
    always_ff @(posedge clk)
    begin
        if (state_reg == S_INIT)
            head_mem[clr_reg] <= '0;
        if (state_reg == S_ADD_WR)
        begin
            pt_mem[cnt_idx]  <= {oz_reg, oy_reg, ox_reg};
            key_mem[cnt_idx] <= key_reg;
            tail_mem[key_reg] <= cnt_idx;
            if (!hvalid_reg)
                head_mem[key_reg] <= cnt_idx;
        end
        if (state_reg == S_ADD_WR)
            nx_mem[cnt_idx] <= '0;
        else if (state_reg == S_ADD_LINK)
            nx_mem[tail_q] <= {1'b1, cnt_idx};
        if (state_reg == S_HRD)
        begin
            head_q <= head_mem[key_reg];
            tail_q <= tail_mem[key_reg];
        end
        if (state_reg == S_KRD)
            kq <= key_mem[head_q];
        if (state_reg == S_SCAN)
        begin
            pt_q <= pt_mem[cur_reg];
            nx_q <= nx_mem[cur_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ret_reg       <= S_IDLE;
            spacing_reg   <= shg_pkg::SPACING_RESET;
            rx_reg        <= shg_pkg::RES_MAX;
            ry_reg        <= shg_pkg::RES_MAX;
            rz_reg        <= shg_pkg::RES_MAX;
            cmd_reg       <= shg_pkg::CMD_CLEAR;
            ox_reg        <= '0;
            oy_reg        <= '0;
            oz_reg        <= '0;
            rad_reg       <= '0;
            count_reg     <= '0;
            axis_reg      <= '0;
            cneg_reg      <= 1'b0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            wz_reg        <= '0;
            dpos_reg      <= '0;
            cidx_reg      <= '0;
            key_reg       <= '0;
            clr_reg       <= '0;
            cur_reg       <= '0;
            n_reg         <= '0;
            any_reg       <= 1'b0;
            trunc_reg     <= 1'b0;
            hvalid_reg    <= 1'b0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (shg_pkg::reg_idx_t'(cfg_index))
                    shg_pkg::REG_SPACING: spacing_reg <= cfg_data;
                    shg_pkg::REG_RES_X:   rx_reg <= cfg_data[4:0];
                    shg_pkg::REG_RES_Y:   ry_reg <= cfg_data[4:0];
                    shg_pkg::REG_RES_Z:   rz_reg <= cfg_data[4:0];
                    default:              rx_reg <= rx_reg;
                endcase
                count_reg <= '0;
            end
            case (state_reg)
                S_INIT:
                begin
                    clr_reg <= clr_reg + 12'd1;
                    if (clr_reg == '1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        cmd_reg   <= shg_pkg::cmd_t'(cmd);
                        ox_reg    <= coord_x;
                        oy_reg    <= coord_y;
                        oz_reg    <= coord_z;
                        rad_reg   <= radius;
                        axis_reg  <= '0;
                        cidx_reg  <= '0;
                        n_reg     <= '0;
                        any_reg   <= 1'b0;
                        trunc_reg <= 1'b0;
                        if (shg_pkg::cmd_t'(cmd) == shg_pkg::CMD_CLEAR)
                        begin
                            count_reg     <= '0;
                            out_reg       <= shg_pkg::mk_out(shg_pkg::KIND_ACK, '0, '0,
                                                             1'b0, 1'b0, 1'b0, 1'b1);
                            out_valid_reg <= 1'b1;
                            ret_reg       <= S_IDLE;
                            state_reg     <= S_OUT;
                        end
                        else if (shg_pkg::cmd_t'(cmd) == shg_pkg::CMD_ADD &&
                                 count_reg >= shg_pkg::COUNT_W'(shg_pkg::MAX_POINTS))
                        begin
                            out_reg       <= shg_pkg::mk_out(shg_pkg::KIND_ACK, '0, '0,
                                                             1'b0, 1'b0, 1'b1, 1'b1);
                            out_valid_reg <= 1'b1;
                            ret_reg       <= S_IDLE;
                            state_reg     <= S_OUT;
                        end
                        else
                            state_reg <= S_SGO;
                    end
                end
                S_SGO:
                    state_reg <= S_DIV_S;
                S_DIV_S:
                begin
                    if (div_res.done)
                    begin
                        cneg_reg <= cneg;
                        dpos_reg[axis_reg] <= dpos;
                        state_reg <= S_DIV_R;
                    end
                end
                S_DIV_R:
                begin
                    if (div_res.done)
                    begin
                        case (axis_reg)
                            2'd0:    wx_reg <= wnew;
                            2'd1:    wy_reg <= wnew;
                            default: wz_reg <= wnew;
                        endcase
                        if (axis_reg == 2'd2)
                            state_reg <= S_KEY;
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= S_SGO;
                        end
                    end
                end
                S_KEY:
                begin
                    key_reg   <= key_c;
                    state_reg <= S_HRD;
                end
                S_HRD:
                    state_reg <= S_KRD;
                S_KRD:
                    state_reg <= S_CHK;
                S_CHK:
                begin
                    hvalid_reg <= hv;
                    if (cmd_reg == shg_pkg::CMD_ADD)
                        state_reg <= S_ADD_WR;
                    else if (hv)
                    begin
                        cur_reg   <= head_q;
                        state_reg <= S_SCAN;
                    end
                    else if (cidx_reg == shg_pkg::CELL_W'(shg_pkg::NEAR_CELLS - 1))
                    begin
                        out_reg       <= shg_pkg::mk_out(shg_pkg::KIND_FINISH, '0, '0,
                                                         any_reg, trunc_reg, 1'b0, 1'b1);
                        out_valid_reg <= 1'b1;
                        ret_reg       <= S_IDLE;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        cidx_reg  <= cidx_reg + 3'd1;
                        state_reg <= S_KEY;
                    end
                end
                S_ADD_WR:
                begin
                    if (hvalid_reg)
                        state_reg <= S_ADD_LINK;
                    else
                    begin
                        count_reg     <= count_reg + 11'd1;
                        out_reg       <= shg_pkg::mk_out(shg_pkg::KIND_ACK, cnt_idx, '0,
                                                         1'b0, 1'b0, 1'b0, 1'b1);
                        out_valid_reg <= 1'b1;
                        ret_reg       <= S_IDLE;
                        state_reg     <= S_OUT;
                    end
                end
                S_ADD_LINK:
                begin
                    count_reg     <= count_reg + 11'd1;
                    out_reg       <= shg_pkg::mk_out(shg_pkg::KIND_ACK, cnt_idx, '0,
                                                     1'b0, 1'b0, 1'b0, 1'b1);
                    out_valid_reg <= 1'b1;
                    ret_reg       <= S_IDLE;
                    state_reg     <= S_OUT;
                end
                S_SCAN:
                    state_reg <= S_DGO;
                S_DGO:
                    state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (dist_res.done)
                    begin
                        if (!dist_res.hit)
                            state_reg <= S_NEXT;
                        else if (cmd_reg == shg_pkg::CMD_ANY)
                        begin
                            out_reg       <= shg_pkg::mk_out(shg_pkg::KIND_FINISH, '0, '0,
                                                             1'b1, 1'b0, 1'b0, 1'b1);
                            out_valid_reg <= 1'b1;
                            ret_reg       <= S_IDLE;
                            state_reg     <= S_OUT;
                        end
                        else
                        begin
                            any_reg <= 1'b1;
                            if (n_reg < shg_pkg::MATCH_W'(MAX_MATCHES))
                            begin
                                n_reg         <= n_reg + 6'd1;
                                out_reg       <= shg_pkg::mk_out(shg_pkg::KIND_MATCH, cur_reg,
                                                                 pt_q, 1'b0, 1'b0, 1'b0, 1'b0);
                                out_valid_reg <= 1'b1;
                                ret_reg       <= S_NEXT;
                                state_reg     <= S_OUT;
                            end
                            else
                            begin
                                trunc_reg <= 1'b1;
                                state_reg <= S_NEXT;
                            end
                        end
                    end
                end
                S_NEXT:
                begin
                    if (nx_q[PW])
                    begin
                        cur_reg   <= nx_q[PW-1:0];
                        state_reg <= S_SCAN;
                    end
                    else if (cidx_reg == shg_pkg::CELL_W'(shg_pkg::NEAR_CELLS - 1))
                    begin
                        out_reg       <= shg_pkg::mk_out(shg_pkg::KIND_FINISH, '0, '0,
                                                         any_reg, trunc_reg, 1'b0, 1'b1);
                        out_valid_reg <= 1'b1;
                        ret_reg       <= S_IDLE;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        cidx_reg  <= cidx_reg + 3'd1;
                        state_reg <= S_KEY;
                    end
                end
                S_OUT:
                begin
                    if (out_acc)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ret_reg;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall    = state_reg != S_IDLE;
    assign out_valid   = out_valid_reg;
    assign kind        = out_reg.kind;
    assign point_index = out_reg.idx;
    assign match_x     = out_reg.x;
    assign match_y     = out_reg.y;
    assign match_z     = out_reg.z;
    assign found       = out_reg.found;
    assign truncated   = out_reg.trunc;
    assign status      = out_reg.status;
    assign last        = out_reg.last;

    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == S_OUT)
        else $error("result valid outside output state");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> !out_valid_reg)
        else $error("request taken while a result is pending");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= shg_pkg::COUNT_W'(shg_pkg::MAX_POINTS))
        else $error("point count overflow");

    a_match_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && out_reg.kind == shg_pkg::KIND_MATCH) |->
        n_reg <= shg_pkg::MATCH_W'(MAX_MATCHES))
        else $error("too many matches");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hashed 3D grid point store: clear, add, radius
// and any-near requests are driven under random idling and compared against
// an in-bench model of the store, bucket lists and query scan.
// ----------------------------------------------------------------------------
module tb_top;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [31:0] coord_x, coord_y, coord_z;
    logic [30:0] radius;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [9:0]  point_index;
    logic [31:0] match_x, match_y, match_z;
    logic        found, truncated, status, last;

    spatial_hash_grid_neighbor_search u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .radius(radius),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
        .point_index(point_index), .match_x(match_x), .match_y(match_y),
        .match_z(match_z), .found(found), .truncated(truncated), .status(status),
        .last(last)
    );

    // grid model
    logic [30:0] g_spacing;
    logic [4:0]  g_res[3];
    logic signed [31:0] pts[shg_pkg::MAX_POINTS][3];
    int  link_next[shg_pkg::MAX_POINTS];
    bit  link_ok[shg_pkg::MAX_POINTS];
    int  head_of[shg_pkg::MAX_BUCKETS];
    bit  head_ok[shg_pkg::MAX_BUCKETS];
    int  tail_of[shg_pkg::MAX_BUCKETS];
    int  num_points;

    shg_pkg::out_t expected_results[$];
    int   errors = 0;
    int   cycles = 0;
    int   hold_off = 0;
    int   hold_req = 0;
    int   hold_seen = 0;
    bit   burst_mode;
    int   burst_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint spacing_eff();
        return (g_spacing == 0) ? 64'sd1 : longint'(g_spacing);
    endfunction

    function automatic longint res_of(int a);
        return (g_res[a] == 0) ? 1 : ((g_res[a] > 16) ? 16 : longint'(g_res[a]));
    endfunction

    function automatic longint floor_cell(longint c);
        longint s, q;
        s = spacing_eff();
        q = c / s;
        if (c % s != 0 && c < 0)
            q--;
        return q;
    endfunction

    function automatic longint wrap_mod(longint v, longint r);
        longint m;
        m = v % r;
        return (m < 0) ? m + r : m;
    endfunction

    function automatic int bucket_key(longint cx, longint cy, longint cz);
        longint k;
        k = (wrap_mod(cz, res_of(2)) * res_of(1) + wrap_mod(cy, res_of(1))) * res_of(0)
            + wrap_mod(cx, res_of(0));
        return int'(k % shg_pkg::MAX_BUCKETS);
    endfunction

    function automatic bit in_radius(int i, longint o[3], longint unsigned r);
        longint unsigned d[3];
        longint diff;
        for (int a = 0; a < 3; a++)
        begin
            diff = longint'(pts[i][a]) - o[a];
            d[a] = (diff < 0) ? -diff : diff;
            if (d[a] > r)
                return 1'b0;
        end
        return (d[0] * d[0] + d[1] * d[1] + d[2] * d[2]) <= r * r;
    endfunction

    function automatic void empty_grid();
        for (int b = 0; b < shg_pkg::MAX_BUCKETS; b++)
            head_ok[b] = 1'b0;
        num_points = 0;
    endfunction

    function automatic void push_result(shg_pkg::kind_t k, int idx, logic [31:0] x,
                                        logic [31:0] y, logic [31:0] z, bit f, bit t,
                                        bit s, bit l);
        shg_pkg::out_t o;
        o.kind = k; o.idx = idx[9:0]; o.x = x; o.y = y; o.z = z;
        o.found = f; o.trunc = t; o.status = s; o.last = l;
        expected_results.insert(expected_results.size(), o);
    endfunction

    function automatic void predict_request(shg_pkg::cmd_t c, logic [31:0] px,
                                            logic [31:0] py, logic [31:0] pz,
                                            logic [30:0] rad);
        longint o[3], cell_idx[3], dir[3], s, r;
        int k, i, n, hit_count, guard;
        bit ok;
        o[0] = longint'($signed(px));
        o[1] = longint'($signed(py));
        o[2] = longint'($signed(pz));
        r = longint'(rad);
        s = spacing_eff();
        n = 0;
        hit_count = 0;
        if (c == shg_pkg::CMD_CLEAR)
        begin
            empty_grid();
            push_result(shg_pkg::KIND_ACK, 0, 0, 0, 0, 0, 0, 0, 1);
            return;
        end
        if (c == shg_pkg::CMD_ADD)
        begin
            if (num_points >= shg_pkg::MAX_POINTS)
            begin
                push_result(shg_pkg::KIND_ACK, 0, 0, 0, 0, 0, 0, 1, 1);
                return;
            end
            i = num_points++;
            for (int a = 0; a < 3; a++)
                pts[i][a] = 32'(o[a]);
            link_ok[i] = 1'b0;
            k = bucket_key(floor_cell(o[0]), floor_cell(o[1]), floor_cell(o[2]));
            if (head_ok[k])
            begin
                link_next[tail_of[k]] = i;
                link_ok[tail_of[k]] = 1'b1;
            end
            else
            begin
                head_of[k] = i;
                head_ok[k] = 1'b1;
            end
            tail_of[k] = i;
            push_result(shg_pkg::KIND_ACK, i, 0, 0, 0, 0, 0, 0, 1);
            return;
        end
        for (int a = 0; a < 3; a++)
        begin
            cell_idx[a] = floor_cell(o[a]);
            dir[a] = ((2 * cell_idx[a] + 1) * s <= 2 * o[a]) ? 1 : -1;
        end
        for (int nc = 0; nc < shg_pkg::NEAR_CELLS; nc++)
        begin
            k = bucket_key(cell_idx[0] + (nc[2] ? dir[0] : 0),
                           cell_idx[1] + (nc[1] ? dir[1] : 0),
                           cell_idx[2] + (nc[0] ? dir[2] : 0));
            ok = head_ok[k];
            i = head_of[k];
            guard = 0;
            while (ok && guard < shg_pkg::MAX_POINTS)
            begin
                if (in_radius(i, o, r))
                begin
                    hit_count++;
                    if (c == shg_pkg::CMD_ANY)
                    begin
                        push_result(shg_pkg::KIND_FINISH, 0, 0, 0, 0, 1, 0, 0, 1);
                        return;
                    end
                    if (n < shg_pkg::MAX_MATCHES_DEF)
                    begin
                        push_result(shg_pkg::KIND_MATCH, i, pts[i][0], pts[i][1], pts[i][2],
                                    0, 0, 0, 0);
                        n++;
                    end
                end
                ok = link_ok[i];
                i = link_next[i];
                guard++;
            end
        end
        push_result(shg_pkg::KIND_FINISH, 0, 0, 0, 0, hit_count != 0,
                    hit_count > shg_pkg::MAX_MATCHES_DEF, 0, 1);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        shg_pkg::out_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result kind", kind, 0);
            else
            begin
                e = expected_results.pop_front();
                if (kind != e.kind)        report_mismatch("kind", kind, e.kind);
                if (point_index != e.idx)  report_mismatch("point_index", point_index, e.idx);
                if (match_x != e.x)        report_mismatch("match_x", match_x, e.x);
                if (match_y != e.y)        report_mismatch("match_y", match_y, e.y);
                if (match_z != e.z)        report_mismatch("match_z", match_z, e.z);
                if (found != e.found)      report_mismatch("found", found, e.found);
                if (truncated != e.trunc)  report_mismatch("truncated", truncated, e.trunc);
                if (status != e.status)    report_mismatch("status", status, e.status);
                if (last != e.last)        report_mismatch("last", last, e.last);
            end
        end
    end

    // receiver stall pattern, with long hold-off on demand
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_off <= 600;
            out_stall <= 1'b1;
        end
        else if (hold_off > 0)
        begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else if (burst_left > 0)
        begin
            out_stall <= 1'b0;
            burst_left <= burst_left - 1;
        end
        else if ($urandom_range(0, 15) == 0)
            burst_left <= $urandom_range(10, 80);
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    task automatic send_request(shg_pkg::cmd_t c, logic [31:0] x, logic [31:0] y,
                                logic [31:0] z, logic [30:0] rad);
        int gap;
        if (!burst_mode && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        if ($urandom_range(0, 7) == 0)
            burst_mode = !burst_mode;
        in_valid <= 1'b1;
        cmd <= c;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        radius <= rad;
        predict_request(c, x, y, z, rad);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(shg_pkg::reg_idx_t idx, logic [30:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            shg_pkg::REG_SPACING: g_spacing = value;
            shg_pkg::REG_RES_X:   g_res[0] = value[4:0];
            shg_pkg::REG_RES_Y:   g_res[1] = value[4:0];
            default:              g_res[2] = value[4:0];
        endcase
        empty_grid();
    endtask

    task automatic set_grid(logic [30:0] sp, logic [4:0] rx, logic [4:0] ry, logic [4:0] rz);
        write_reg(shg_pkg::REG_SPACING, sp);
        write_reg(shg_pkg::REG_RES_X, {26'd0, rx});
        write_reg(shg_pkg::REG_RES_Y, {26'd0, ry});
        write_reg(shg_pkg::REG_RES_Z, {26'd0, rz});
    endtask

    function automatic logic [31:0] near_coord(logic [31:0] base, int span);
        return base + $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic shg_pkg::cmd_t random_query();
        return ($urandom_range(0, 2) == 0) ? shg_pkg::CMD_ANY : shg_pkg::CMD_ALL;
    endfunction

    task automatic test_directed();
        send_request(shg_pkg::CMD_CLEAR, 0, 0, 0, 0);
        send_request(shg_pkg::CMD_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 0);
        send_request(shg_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0);
        send_request(shg_pkg::CMD_ADD, 32'h0001_8000, 32'h0000_8000, 32'hFFFF_8000, 0);
        send_request(shg_pkg::CMD_ADD, 32'h0001_8000, 32'h0000_8000, 32'hFFFF_8000, 0);
        send_request(shg_pkg::CMD_ALL, 32'h0001_8000, 32'h0000_8000, 32'hFFFF_8000, 0);
        send_request(shg_pkg::CMD_ALL, 32'h0001_0000, 32'h0000_C000, 32'hFFFF_0000,
                     31'h0001_0000);
        send_request(shg_pkg::CMD_ANY, 32'h0001_8000, 32'h0000_8000, 32'hFFFF_8000, 0);
        send_request(shg_pkg::CMD_ANY, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 31'h10);
        send_request(shg_pkg::CMD_ALL, 32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF);
        send_request(shg_pkg::CMD_ANY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     31'h7FFF_FFFF);
        send_request(shg_pkg::CMD_CLEAR, 0, 0, 0, 0);
        send_request(shg_pkg::CMD_ALL, 0, 0, 0, 31'h7FFF_FFFF);
    endtask

    // resolution 1 in x and y makes neighbors along those axes the same bucket: repeated reports
    task automatic test_repeated_cells();
        set_grid(31'h0001_0000, 5'd1, 5'd0, 5'd31);
        for (int i = 0; i < 5; i++)
            send_request(shg_pkg::CMD_ADD, $urandom_range(0, 32'h3_0000), $urandom, $urandom,
                         0);
        send_request(shg_pkg::CMD_ALL, 32'h1_0000, 32'h0, 32'h0, 31'h7FFF_FFFF);
    endtask

    task automatic test_truncation();
        set_grid(31'h0010_0000, 5'd16, 5'd16, 5'd16);
        for (int i = 0; i < 70; i++)
            send_request(shg_pkg::CMD_ADD, $urandom_range(0, 32'hF_FFFF),
                         $urandom_range(0, 32'hF_FFFF), $urandom_range(0, 32'hF_FFFF), 0);
        send_request(shg_pkg::CMD_ALL, 32'h8_0000, 32'h8_0000, 32'h8_0000, 31'h0040_0000);
        send_request(shg_pkg::CMD_ANY, 32'h8_0000, 32'h8_0000, 32'h8_0000, 31'h0040_0000);
    endtask

    task automatic test_backpressure();
        hold_req++;
        for (int i = 0; i < 8; i++)
            send_request(shg_pkg::CMD_ADD, $urandom, $urandom, $urandom, 0);
        wait_drained();
    endtask

    task automatic test_random(int count, int span);
        logic [31:0] bx, by, bz;
        bx = $urandom;
        by = $urandom;
        bz = $urandom;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 19)) inside
                0:
                    send_request(shg_pkg::CMD_CLEAR, $urandom, $urandom, $urandom,
                                 31'($urandom));
                [1:9]:
                    send_request(shg_pkg::CMD_ADD, near_coord(bx, span), near_coord(by, span),
                                 near_coord(bz, span), 31'($urandom));
                10:
                    send_request(random_query(), $urandom, $urandom, $urandom, 31'($urandom));
                default:
                    send_request(random_query(), near_coord(bx, span), near_coord(by, span),
                                 near_coord(bz, span), 31'($urandom_range(0, 2 * span)));
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = '0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        radius = '0;
        burst_mode = 1'b0;
        g_spacing = shg_pkg::SPACING_RESET;
        g_res[0] = shg_pkg::RES_MAX;
        g_res[1] = shg_pkg::RES_MAX;
        g_res[2] = shg_pkg::RES_MAX;
        empty_grid();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_repeated_cells();
        test_truncation();
        test_backpressure();
        set_grid(31'h0000_4000, 5'd3, 5'd7, 5'd16);
        test_random(130, 32'h0001_0000);
        set_grid(31'h7FFF_FFFF, 5'd16, 5'd2, 5'd5);
        test_random(60, 32'h0100_0000);
        set_grid(31'd0, 5'd5, 5'd16, 5'd1);
        test_random(60, 32'h40);
        set_grid(31'h0002_0000, 5'd16, 5'd16, 5'd16);
        test_random(60, 32'h0004_0000);
        wait_drained();
        repeat (300) @(negedge clk);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> files.f
sv/shg_pkg.sv
sv/shg_div.sv
sv/shg_dist.sv
sv/spatial_hash_grid_neighbor_search.sv
bench/tb_top.sv
